>>> hdl/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Types and constants shared by the x86 branch address converter modules.
// ----------------------------------------------------------------------------
package bac_pkg;

  // Lookahead window: six bytes, entry 0 is the oldest (next to leave)
  localparam int unsigned WinLen = 6;
  typedef logic [WinLen-1:0][7:0] bac_win_t;

  // Opcode and operand patterns
  localparam logic [7:0] OpJccPrefix = 8'h0F;
  localparam logic [7:0] JccHiMask   = 8'hF0;
  localparam logic [7:0] JccHiCode   = 8'h80;
  localparam logic [7:0] OpCall      = 8'hE8;
  localparam logic [7:0] OpJmp       = 8'hE9;
  localparam logic [7:0] TopAllZero  = 8'h00;
  localparam logic [7:0] TopAllOne   = 8'hFF;
  localparam logic [2:0] MaskKeep    = 3'h7;

  // Instruction lengths and consumed-byte codes
  localparam logic [2:0] LenNone = 3'd0;  // conversion stops
  localparam logic [2:0] LenOne  = 3'd1;
  localparam logic [2:0] LenRel  = 3'd5;  // E8 / E9
  localparam logic [2:0] LenJcc  = 3'd6;  // 0F 8x
  localparam logic [2:0] RemFull = 3'd6;
  localparam logic [2:0] RemJccMin = 3'd2;
  localparam logic [2:0] DistSat = 3'd6;
  localparam logic [2:0] DistMax = 3'd5;

  // Position register holds start + index + length of a near branch
  localparam logic [31:0] PosRelOffset = 32'd5;

  // Configuration register indexes
  typedef enum logic [0:0] {
    BAC_REG_DECODE_MODE = 1'b0,
    BAC_REG_START_POS   = 1'b1
  } bac_reg_e;

  // Front state: filling / streaming, or flushing after the last byte
  typedef enum logic [0:0] {
    BAC_FILL  = 1'b0,
    BAC_FLUSH = 1'b1
  } bac_state_e;

  // Branch history carried between decisions
  typedef struct packed {
    logic [3:0] mask;
    logic [2:0] mark_dist;
  } bac_hist_t;

  // Outcome of one decision
  typedef struct packed {
    logic [2:0] used;   // bytes consumed, LenNone stops conversion
    bac_hist_t  hist;
  } bac_dec_t;

  // One result byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } bac_res_t;

endpackage

>>> hdl/bac_classify.sv
// ----------------------------------------------------------------------------
// bac_classify
// Classifies the byte at the window front and rewrites a branch operand.
// ----------------------------------------------------------------------------
module bac_classify (
  input  bac_pkg::bac_win_t  win_i,
  input  logic [2:0]         rem_i,
  input  bac_pkg::bac_hist_t hist_i,
  input  logic               decode_i,
  input  logic [31:0]        pos5_i,
  output bac_pkg::bac_dec_t  dec_o,
  output bac_pkg::bac_win_t  win_o
);

  logic        is_jcc;
  logic        is_rel;
  logic [2:0]  shamt;
  logic [7:0]  shifted;
  logic [2:0]  mask_sh;
  logic        skip;
  logic [31:0] operand;
  logic [31:0] addend;
  logic        carry_in;
  logic [31:0] sum;

  // Opcode match
  assign is_jcc = (win_i[0] == bac_pkg::OpJccPrefix) && (rem_i >= bac_pkg::RemJccMin) &&
                  ((win_i[1] & bac_pkg::JccHiMask) == bac_pkg::JccHiCode);
  assign is_rel = (win_i[0] == bac_pkg::OpCall) || (win_i[0] == bac_pkg::OpJmp);

  // Age the marker mask by the distance to the previous marker
  assign shamt   = (hist_i.mark_dist == '0) ? 3'd0 : hist_i.mark_dist - 3'd1;
  assign shifted = {4'b0, hist_i.mask} << shamt;
  assign mask_sh = (hist_i.mark_dist > bac_pkg::DistMax) ? 3'd0 :
                   (shifted[2:0] & bac_pkg::MaskKeep);
  assign skip    = (mask_sh != '0) &&
                   ((mask_sh[0] && (win_i[4] == bac_pkg::TopAllZero)) ||
                    (mask_sh[1] && (win_i[4] == bac_pkg::TopAllOne)));

  // Single adder: operand +/- (position + length); length 6 via carry trick
  assign operand  = is_jcc ? win_i[5:2] : win_i[4:1];
  assign addend   = decode_i ? pos5_i : ~pos5_i;
  assign carry_in = decode_i ? is_jcc : ~is_jcc;
  assign sum      = operand + addend + {31'b0, carry_in};

  // Decision
  always_comb begin
    dec_o.used = bac_pkg::LenOne;
    dec_o.hist = hist_i;
    win_o      = win_i;
    if (is_jcc) begin
      if (rem_i >= bac_pkg::RemFull) begin
        dec_o.used           = bac_pkg::LenJcc;
        dec_o.hist.mask      = '0;
        dec_o.hist.mark_dist = '0;
        win_o[5:2]           = sum;
      end
    end else if (is_rel) begin
      if (rem_i < bac_pkg::LenRel) begin
        dec_o.used = bac_pkg::LenNone;
      end else begin
        dec_o.hist.mark_dist = '0;
        dec_o.hist.mask      = {mask_sh, 1'b1};
        if (!skip) begin
          dec_o.used = bac_pkg::LenRel;
          win_o[4:1] = sum;
        end
      end
    end
  end

endmodule

>>> hdl/bac_front.sv
// ----------------------------------------------------------------------------
// bac_front
// Accepts bytes into the lookahead window, holds configuration and branch
// history, makes at most one decision per emitted byte and sequences the flush.
// ----------------------------------------------------------------------------
module bac_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [7:0]        data_byte_i,
  input  logic              is_last_i,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              q_full_i,
  output logic              full_o,
  output logic              emit_valid_o,
  output bac_pkg::bac_res_t emit_o
);

  bac_pkg::bac_state_e state_q, state_d;
  bac_pkg::bac_win_t   win_q, win_d;
  logic [2:0]          fill_q, fill_d;
  bac_pkg::bac_hist_t  hist_q, hist_d;
  logic [2:0]          pass_q, pass_d;
  logic                stop_q, stop_d;
  logic [31:0]         idx5_q, idx5_d;
  logic [31:0]         pos5_q, pos5_d;
  logic                decode_q, decode_d;
  logic [31:0]         start_q, start_d;

  bac_pkg::bac_win_t   win_in;
  bac_pkg::bac_win_t   cls_win;
  bac_pkg::bac_win_t   cls_win_new;
  bac_pkg::bac_win_t   next_win;
  logic [2:0]          cls_rem;
  bac_pkg::bac_dec_t   dec;
  bac_pkg::bac_hist_t  hist_nx;
  logic                flushing;
  logic                accept;
  logic                step;
  logic                do_dec;

  // Window with the incoming byte placed at the fill slot
  always_comb begin
    win_in = win_q;
    for (int i = 0; i < bac_pkg::WinLen; i++) begin
      if (fill_q == 3'(i)) win_in[i] = data_byte_i;
    end
  end

  assign flushing = (state_q == bac_pkg::BAC_FLUSH);
  assign full_o   = flushing || q_full_i;
  assign accept   = push_i && !full_o;
  assign step     = (accept && !is_last_i && (fill_q == 3'(bac_pkg::WinLen - 1))) ||
                    (flushing && !q_full_i);
  assign do_dec   = (pass_q == '0) && !stop_q;

  assign cls_win = flushing ? win_q : win_in;
  assign cls_rem = flushing ? fill_q : bac_pkg::RemFull;

  bac_classify u_classify (
    .win_i    (cls_win),
    .rem_i    (cls_rem),
    .hist_i   (hist_q),
    .decode_i (decode_q),
    .pos5_i   (pos5_q),
    .dec_o    (dec),
    .win_o    (cls_win_new)
  );

  // Rewritten window moves one byte towards the front
  always_comb begin
    next_win = do_dec ? cls_win_new : cls_win;
    next_win = {next_win[5], next_win[5:1]};
  end

  // History after the decision, distance aged by the byte leaving
  always_comb begin
    hist_nx = do_dec ? dec.hist : hist_q;
    if (hist_nx.mark_dist < bac_pkg::DistSat) hist_nx.mark_dist = hist_nx.mark_dist + 3'd1;
  end

  // Next state and result
  always_comb begin
    state_d      = state_q;
    win_d        = win_q;
    fill_d       = fill_q;
    hist_d       = hist_q;
    pass_d       = pass_q;
    stop_d       = stop_q;
    idx5_d       = idx5_q;
    pos5_d       = pos5_q;
    decode_d     = decode_q;
    start_d      = start_q;
    emit_valid_o = 1'b0;
    emit_o.data  = cls_win[0];
    emit_o.last  = flushing && (fill_q == 3'd1);

    if (accept && (is_last_i || (fill_q != 3'(bac_pkg::WinLen - 1)))) begin
      win_d  = win_in;
      fill_d = fill_q + 3'd1;
      if (is_last_i) state_d = bac_pkg::BAC_FLUSH;
    end

    if (step) begin
      emit_valid_o = 1'b1;
      win_d        = next_win;
      hist_d       = hist_nx;
      idx5_d       = idx5_q + 32'd1;
      pos5_d       = pos5_q + 32'd1;
      if (pass_q != '0) begin
        pass_d = pass_q - 3'd1;
      end else if (do_dec) begin
        if (dec.used == bac_pkg::LenNone) stop_d = 1'b1;
        else pass_d = dec.used - 3'd1;
      end
      if (flushing) begin
        fill_d = fill_q - 3'd1;
        // final byte leaves: stream state back to its start-of-buffer values
        if (fill_q == 3'd1) begin
          state_d          = bac_pkg::BAC_FILL;
          fill_d           = '0;
          hist_d.mask      = '0;
          hist_d.mark_dist = bac_pkg::DistSat;
          pass_d           = '0;
          stop_d           = 1'b0;
          idx5_d           = bac_pkg::PosRelOffset;
          pos5_d           = start_q + bac_pkg::PosRelOffset;
        end
      end
    end

    // The user must write configuration only while idle; the block does not enforce it
    if (cfg_we_i) begin
      case (bac_pkg::bac_reg_e'(cfg_idx_i))
        bac_pkg::BAC_REG_DECODE_MODE: decode_d = cfg_wdata_i[0];
        bac_pkg::BAC_REG_START_POS: begin
          start_d = cfg_wdata_i;
          pos5_d  = cfg_wdata_i + idx5_d;
        end
        default: ;
      endcase
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bac_pkg::BAC_FILL;
      fill_q    <= '0;
      hist_q    <= '{mask: 4'd0, mark_dist: bac_pkg::DistSat};
      pass_q    <= '0;
      stop_q    <= 1'b0;
      idx5_q    <= bac_pkg::PosRelOffset;
      pos5_q    <= bac_pkg::PosRelOffset;
      decode_q  <= 1'b0;
      start_q   <= '0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      hist_q    <= hist_d;
      pass_q    <= pass_d;
      stop_q    <= stop_d;
      idx5_q    <= idx5_d;
      pos5_q    <= pos5_d;
      decode_q  <= decode_d;
      start_q   <= start_d;
    end
  end

  // Window bytes (payload, slots beyond the fill count are never read)
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

endmodule

>>> hdl/bac_queue.sv
// ----------------------------------------------------------------------------
// bac_queue
// Small result queue between the front and the result ports.
// ----------------------------------------------------------------------------
module bac_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  bac_pkg::bac_res_t wr_data_i,
  input  logic              rd_en_i,
  output bac_pkg::bac_res_t rd_data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bac_pkg::bac_res_t mem_q [Depth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_wr, do_rd;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_q];

  // Pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      if (do_rd) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_q] <= wr_data_i;
  end

endmodule

>>> hdl/x86_branch_address_converter_top.sv
// ----------------------------------------------------------------------------
// x86_branch_address_converter_top
// Streaming x86 branch operand converter (encode / decode), queue ports.
// ----------------------------------------------------------------------------
// One byte is accepted per clock while full is low. The first five bytes of a
// buffer fill the lookahead window and give no result; from then on every
// accepted byte but the last pushes one result byte into the result queue as
// it is accepted. A byte with is_last starts a flush: the held bytes (up to
// six) leave at one per cycle while the queue has room, full staying high,
// and the stream state is then back at its start-of-buffer values. The rate
// is set by the window register and the single 32-bit operand adder, which
// together finish one decision per cycle while the queue has room; the result
// queue (QueueDepth entries) lets the input side go on while results wait to be popped.
module x86_branch_address_converter_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input queue side
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        is_last_i,
  // result queue side
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte_o,
  output logic        out_last_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i
);

  bac_pkg::bac_res_t emit;
  bac_pkg::bac_res_t head;
  logic              emit_valid;
  logic              q_full;

  // Front: window, decisions, flush sequencing
  bac_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_byte_i  (data_byte_i),
    .is_last_i    (is_last_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .q_full_i     (q_full),
    .full_o       (full),
    .emit_valid_o (emit_valid),
    .emit_o       (emit)
  );

  // Back: result queue
  bac_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (emit_valid),
    .wr_data_i (emit),
    .rd_en_i   (pop),
    .rd_data_o (head),
    .full_o    (q_full),
    .empty_o   (empty)
  );

  assign out_byte_o = head.data;
  assign out_last_o = head.last;

endmodule

>>> hdl/bac_checker.sv
// ----------------------------------------------------------------------------
// bac_checker
// Port-level checks on the converter's request ordering, bound to the top.
// ----------------------------------------------------------------------------
module bac_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       is_last_i,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  logic [15:0] pend_q;
  logic [7:0]  lasts_q;
  logic        in_acc, out_acc;

  assign in_acc  = push && !full;
  assign out_acc = pop && !empty;

  // Requests in flight and buffer ends not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      lasts_q <= '0;
    end else begin
      pend_q  <= pend_q + {15'b0, in_acc} - {15'b0, out_acc};
      lasts_q <= lasts_q + {7'b0, in_acc && is_last_i} - {7'b0, out_acc && out_last_o};
    end
  end

  // A result needs an accepted request behind it
  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (pend_q != '0))
    else $error("result shown with no request outstanding");

  // A buffer end is delivered only after one was accepted
  a_last_matched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |-> (lasts_q != '0))
    else $error("buffer end delivered without a last request");

  // The flush holds off the input side
  a_flush_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_last_i) |=> full)
    else $error("input accepted during flush");

  // A waiting result holds
  a_head_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(out_last_o)))
    else $error("waiting result changed");

endmodule

bind x86_branch_address_converter_top bac_checker u_bac_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .is_last_i  (is_last_i),
  .empty      (empty),
  .pop        (pop),
  .out_byte_o (out_byte_o),
  .out_last_o (out_last_o)
);

>>> dv/x86_branch_address_converter_top_tb.sv
// ----------------------------------------------------------------------------
// x86_branch_address_converter_top_tb
// Self-checking bench for the x86 branch operand converter. Code buffers are
// streamed through the input queue, and every output byte is checked against
// a cycle-free model of the window, branch history and operand rewrite.
// Phases throttle one side or both. One phase holds the output
// side off for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module x86_branch_address_converter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HoldLen     = 200;   // long output hold-off, in cycles
  localparam int unsigned DrainCycles = 10;    // flush tail after the last byte out
  localparam int unsigned Limit       = 3000;  // cycles with no request moving
  localparam int unsigned PhaseBytes  = 55;
  localparam int unsigned NumPhases   = 6;

  typedef enum logic [1:0] {
    THROTTLE_NONE,
    THROTTLE_SEND,
    THROTTLE_RECV,
    THROTTLE_BOTH
  } throttle_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } code_byte_t;

  // DUT connections, inputs all known from time zero
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  data_byte_i = 8'h00;
  logic        is_last_i   = 1'b0;
  logic        empty;
  logic        pop         = 1'b0;
  logic [7:0]  out_byte_o;
  logic        out_last_o;
  logic        cfg_we_i    = 1'b0;
  logic [0:0]  cfg_idx_i   = bac_pkg::BAC_REG_DECODE_MODE;
  logic [31:0] cfg_wdata_i = 32'h0;

  // Bench state
  code_byte_t        code_bytes[$];       // bytes waiting to be offered
  bac_pkg::bac_res_t predicted_bytes[$];  // output bytes still to arrive
  throttle_e         throttle     = THROTTLE_NONE;
  logic              pressure_on  = 1'b0;
  int unsigned       hold_cnt     = 0;
  int unsigned       quiet_cnt    = 0;
  int unsigned       mismatch_cnt = 0;

  // Model state
  logic [7:0]  win [bac_pkg::WinLen];
  int unsigned win_fill;
  logic [31:0] pos_index;
  logic [3:0]  hist_mask;
  logic [2:0]  hist_dist;
  logic [2:0]  pass_left;
  logic        conv_stopped;
  logic        cfg_decode;
  logic [31:0] cfg_start;

  x86_branch_address_converter_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .is_last_i   (is_last_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Model of the converter
  // --------------------------------------------------------------------------
  function automatic void clear_stream();
    foreach (win[i]) win[i] = 8'h00;
    win_fill     = 0;
    pos_index    = 32'h0;
    hist_mask    = 4'h0;
    hist_dist    = bac_pkg::DistSat;
    pass_left    = 3'd0;
    conv_stopped = 1'b0;
  endfunction

  // Rebase the little-endian operand at win[at..at+3] against the end address
  function automatic void rebase_operand(int unsigned at, logic [31:0] len);
    logic [31:0] val;
    logic [31:0] end_pos;
    val     = {win[at+3], win[at+2], win[at+1], win[at]};
    end_pos = cfg_start + pos_index + len;
    val     = cfg_decode ? val + end_pos : val - end_pos;
    {win[at+3], win[at+2], win[at+1], win[at]} = val;
  endfunction

  // Branch decision at win[p]; returns bytes consumed, 0 stops conversion
  function automatic int unsigned branch_decision(int unsigned p, int unsigned rem);
    logic [2:0]  gap;
    int unsigned sh;
    logic [7:0]  top;
    if (win[p] == bac_pkg::OpJccPrefix && rem >= bac_pkg::RemJccMin &&
        (win[p+1] & bac_pkg::JccHiMask) == bac_pkg::JccHiCode) begin
      if (rem < bac_pkg::LenJcc) return 1;
      rebase_operand(p + 2, 32'(bac_pkg::LenJcc));
      hist_mask = 4'h0;
      hist_dist = 3'd0;
      return bac_pkg::LenJcc;
    end
    if (win[p] != bac_pkg::OpCall && win[p] != bac_pkg::OpJmp) return 1;
    if (rem < bac_pkg::LenRel) return 0;

    gap       = hist_dist;
    hist_dist = 3'd0;
    if (gap > bac_pkg::DistMax) begin
      hist_mask = 4'h0;
    end else begin
      sh        = (gap != 3'd0) ? gap - 1 : 0;
      hist_mask = (hist_mask << sh) & 4'(bac_pkg::MaskKeep);
      top       = win[p+4];
      // recent history plus a sign-like top byte: leave the operand alone
      if ((hist_mask[0] && top == bac_pkg::TopAllZero) ||
          (hist_mask[1] && top == bac_pkg::TopAllOne)) begin
        hist_mask = {hist_mask[2:0], 1'b1};
        return 1;
      end
    end
    rebase_operand(p + 1, 32'(bac_pkg::LenRel));
    hist_mask = {hist_mask[2:0], 1'b1};
    return bac_pkg::LenRel;
  endfunction

  function automatic void step_position();
    pos_index = pos_index + 32'd1;
    if (hist_dist < bac_pkg::DistSat) hist_dist = hist_dist + 3'd1;
  endfunction

  // One accepted request in, zero or more predicted output bytes queued
  function automatic void convert_byte(code_byte_t req);
    int unsigned       used;
    int unsigned       p;
    bac_pkg::bac_res_t res;
    if (win_fill >= bac_pkg::WinLen) win_fill = bac_pkg::WinLen - 1;
    win[win_fill] = req.data;
    win_fill++;

    if (!req.last) begin
      if (win_fill < bac_pkg::WinLen) return;
      if (pass_left != 3'd0) begin
        pass_left = pass_left - 3'd1;
      end else begin
        used      = branch_decision(0, bac_pkg::WinLen);
        pass_left = (used != 0) ? 3'(used - 1) : 3'd0;
      end
      res.data = win[0];
      res.last = 1'b0;
      predicted_bytes.push_back(res);
      for (int i = 0; i < bac_pkg::WinLen - 1; i++) win[i] = win[i+1];
      win[bac_pkg::WinLen-1] = 8'h00;
      win_fill               = bac_pkg::WinLen - 1;
      step_position();
      return;
    end

    // flush: every held byte leaves, the last one flagged
    for (p = 0; p < win_fill; p++) begin
      if (pass_left != 3'd0) begin
        pass_left = pass_left - 3'd1;
      end else if (!conv_stopped) begin
        used = branch_decision(p, win_fill - p);
        if (used == 0) conv_stopped = 1'b1;
        else           pass_left    = 3'(used - 1);
      end
      res.data = win[p];
      res.last = (p + 1 == win_fill);
      predicted_bytes.push_back(res);
      step_position();
    end
    clear_stream();
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      logic gap_now;
      logic taken;
      taken = push && !full;
      if (taken) begin
        convert_byte(code_bytes.pop_front());
      end
      gap_now = (throttle == THROTTLE_SEND && $urandom_range(99) < 85) ||
                (throttle == THROTTLE_BOTH && $urandom_range(99) < 12);
      if (push && !taken) begin
        // request still pending, hold it
      end else if (code_bytes.size() != 0 && !gap_now) begin
        push        <= 1'b1;
        data_byte_i <= code_bytes[0].data;
        is_last_i   <= code_bytes[0].last;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and checker
  // --------------------------------------------------------------------------
  task automatic note_mismatch(string what, logic [7:0] got, logic [7:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 50)
      $display("%0t mismatch on %s: got %02h, predicted %02h", $realtime, what, got, want);
  endtask

  // Long hold-off on the output side, counted here
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt <= 0;
    end else if (pressure_on && hold_cnt != HoldLen) begin
      hold_cnt <= hold_cnt + 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      bac_pkg::bac_res_t want;
      logic              stall;
      if (pop && !empty) begin
        if (predicted_bytes.size() == 0) begin
          note_mismatch("unpredicted result", out_byte_o, 8'h00);
        end else begin
          want = predicted_bytes.pop_front();
          if (out_byte_o !== want.data) note_mismatch("out_byte", out_byte_o, want.data);
          if (out_last_o !== want.last)
            note_mismatch("out_last", 8'(out_last_o), 8'(want.last));
        end
      end
      stall = (throttle == THROTTLE_RECV && $urandom_range(99) < 85) ||
              (throttle == THROTTLE_BOTH && $urandom_range(99) < 12) ||
              (pressure_on && hold_cnt != HoldLen);
      pop <= !stall;
    end
  end

  // Watchdog: stop when neither side has moved for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt == Limit) begin
        $display("watchdog: no request moved for %0d cycles", Limit);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  // Both registers, written back to back while the block is idle
  task automatic set_mode(logic decode, logic [31:0] start);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= bac_pkg::BAC_REG_DECODE_MODE;
    cfg_wdata_i <= {31'h0, decode};
    @(posedge clk_i);
    cfg_idx_i   <= bac_pkg::BAC_REG_START_POS;
    cfg_wdata_i <= start;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_decode = decode;
    cfg_start  = start;
  endtask

  task automatic wait_idle();
    while (code_bytes.size() != 0 || predicted_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void queue_buffer(logic [7:0] bytes[$]);
    foreach (bytes[i]) code_bytes.push_back('{bytes[i], i == bytes.size() - 1});
  endfunction

  // Random buffer, dense in branch opcodes and sign-like operand bytes
  function automatic void queue_random_buffer(int unsigned len);
    logic [7:0]  bytes[$];
    int unsigned r;
    while (bytes.size() < len) begin
      r = $urandom_range(99);
      if (r < 15)                           bytes.push_back(bac_pkg::OpCall);
      else if (r < 25)                      bytes.push_back(bac_pkg::OpJmp);
      else if (r < 33 && bytes.size() + 1 < len) begin
        bytes.push_back(bac_pkg::OpJccPrefix);
        bytes.push_back(bac_pkg::JccHiCode | 8'($urandom_range(15)));
      end
      else if (r < 43)
        bytes.push_back(r[0] ? bac_pkg::TopAllOne : bac_pkg::TopAllZero);
      else                                  bytes.push_back(8'($urandom));
    end
    queue_buffer(bytes);
  endfunction

  initial begin
    int unsigned left;
    int unsigned len;
    logic        decode;
    logic [31:0] start;
    clear_stream();
    cfg_decode = 1'b0;
    cfg_start  = 32'h0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: converted call, long conditional jump, short jump that stops
    // conversion, short conditional jump, short call, single-byte buffer
    set_mode(1'b0, 32'h0);
    queue_buffer('{bac_pkg::OpCall, 8'h78, 8'h56, 8'h34, 8'h12, bac_pkg::OpJccPrefix,
                   8'h85, 8'h00, 8'h00, 8'h00, bac_pkg::TopAllOne, bac_pkg::OpJmp,
                   bac_pkg::TopAllOne, 8'h00, 8'h00});
    queue_buffer('{bac_pkg::OpJccPrefix, bac_pkg::JccHiCode, 8'h01, 8'h02,
                   bac_pkg::OpCall});
    queue_buffer('{bac_pkg::TopAllOne});
    wait_idle();

    // Random phases, each with its own register setting and throttling
    for (int ph = 0; ph < NumPhases; ph++) begin
      case (ph)
        0: begin decode = 1'b1; start = 32'hFFFF_FFFF; throttle = THROTTLE_SEND; end
        1: begin decode = 1'b0; start = 32'hFFFF_FFF8; throttle = THROTTLE_RECV; end
        2: begin decode = 1'b1; start = $urandom;      throttle = THROTTLE_BOTH; end
        3: begin decode = 1'b0; start = $urandom;      throttle = THROTTLE_NONE; end
        4: begin decode = 1'b0; start = 32'hFFFF_FFFF; throttle = THROTTLE_BOTH; end
        default: begin decode = 1'b1; start = 32'h0;   throttle = THROTTLE_NONE; end
      endcase
      set_mode(decode, start);
      // output side held off while the sender keeps offering
      if (ph == 3) pressure_on = 1'b1;
      left = PhaseBytes;
      while (left != 0) begin
        len = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : $urandom_range(7, 30);
        if (len > left) len = left;
        queue_random_buffer(len);
        left -= len;
      end
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
